@@ hdl/pfd_pkg.sv @@
`timescale 1ns / 1ps

package pfd_pkg;

  // File signatures, as they appear in the byte window (oldest byte high)
  localparam logic [23:0] SIG_ID3    = 24'h494433;
  localparam logic [15:0] SIG_SYNC   = 16'hFFFB;
  localparam logic [31:0] MAGIC_RIFF = 32'h52494646;
  localparam logic [31:0] MAGIC_WAVE = 32'h57415645;
  localparam logic [31:0] SIG_PNG    = 32'h89504E47;
  localparam logic [31:0] SIG_ZIP    = 32'h504B0304;
  localparam logic [15:0] SIG_MZ     = 16'h4D5A;
  localparam logic [31:0] SIG_AUDT   = 32'h61754454;

  // Reset values of the window registers
  localparam logic [7:0]  ID3_WINDOW_RST  = 8'd10;
  localparam logic [15:0] SYNC_WINDOW_RST = 16'd4096;

  // Register index, taken from paddr[2]
  localparam logic REG_ID3_WINDOW  = 1'b0;
  localparam logic REG_SYNC_WINDOW = 1'b1;

  localparam int APB_AW = 3;
  localparam int APB_DW = 32;

  // Bits of the seen-flags vector
  localparam int FLAG_W = 7;
  localparam int F_MP3  = 0;
  localparam int F_ZIP  = 1;
  localparam int F_RIFF = 2;
  localparam int F_WAVE = 3;
  localparam int F_PNG  = 4;
  localparam int F_MZ   = 5;
  localparam int F_STOP = 6;

  typedef enum logic [1:0] {
    PH_LEN,
    PH_TYPE,
    PH_SKIP
  } phase_e;

  typedef struct packed {
    logic        mp3_zip_found;
    logic [31:0] zip_loc;
    logic        wav_exe_found;
    logic [31:0] mz_loc;
    logic        png_audio_found;
    logic [31:0] audio_length;
    logic        any_found;
  } result_t;

endpackage

@@ hdl/pfd_if.sv @@
`timescale 1ns / 1ps

interface pfd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface pfd_out_if;
  logic        valid;
  logic        ready;
  logic        mp3_zip_found;
  logic [31:0] zip_loc;
  logic        wav_exe_found;
  logic [31:0] mz_loc;
  logic        png_audio_found;
  logic [31:0] audio_length;
  logic        any_found;

  modport source (
    output valid, output mp3_zip_found, output zip_loc, output wav_exe_found,
    output mz_loc, output png_audio_found, output audio_length, output any_found,
    input ready
  );
  modport sink (
    input valid, input mp3_zip_found, input zip_loc, input wav_exe_found,
    input mz_loc, input png_audio_found, input audio_length, input any_found,
    output ready
  );
endinterface

@@ hdl/pfd_cfg.sv @@
`timescale 1ns / 1ps

module pfd_cfg (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [pfd_pkg::APB_AW-1:0] paddr,
  input  logic [pfd_pkg::APB_DW-1:0] pwdata,
  output logic [pfd_pkg::APB_DW-1:0] prdata,
  output logic                      pready,
  output logic [7:0]                id3_window_o,
  output logic [15:0]               sync_window_o
);
  import pfd_pkg::*;

  logic        wr_en;
  logic [7:0]  id3_window_q;
  logic [15:0] sync_window_q;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      id3_window_q  <= ID3_WINDOW_RST;
      sync_window_q <= SYNC_WINDOW_RST;
    end else if (wr_en) begin
      if (paddr[2] == REG_ID3_WINDOW) begin
        id3_window_q <= pwdata[7:0];
      end else begin
        sync_window_q <= pwdata[15:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_SYNC_WINDOW) begin
      prdata = {16'd0, sync_window_q};
    end else begin
      prdata = {24'd0, id3_window_q};
    end
  end

  assign id3_window_o  = id3_window_q;
  assign sync_window_o = sync_window_q;

endmodule

@@ hdl/pfd_scan.sv @@
`timescale 1ns / 1ps

module pfd_scan #(
  parameter int POS_WIDTH = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             step_i,
  input  logic [7:0]       data_byte_i,
  input  logic             last_byte_i,
  input  logic [7:0]       id3_window_i,
  input  logic [15:0]      sync_window_i,
  output pfd_pkg::result_t result_o
);
  import pfd_pkg::*;

  localparam logic [POS_WIDTH-1:0] POS_MAX = '1;

  logic [23:0]          hist_q, hist_d;
  logic [POS_WIDTH-1:0] pos_q, pos_d;
  logic [FLAG_W-1:0]    flags_q, flags_d;
  logic [POS_WIDTH-1:0] zip_pos_q, zip_pos_d;
  logic [POS_WIDTH-1:0] mz_pos_q, mz_pos_d;
  phase_e               phase_q, phase_d;
  logic [1:0]           cnt_q, cnt_d;
  logic [31:0]          clen_q, clen_d;
  logic [32:0]          skip_q, skip_d;
  logic [32:0]          hit_q, hit_d;

  logic [15:0]          w2;
  logic [23:0]          w3;
  logic [31:0]          w4;
  logic                 sat;
  logic [32:0]          skip_dec;
  logic [POS_WIDTH+31:0] zip_ext, mz_ext;
  logic                 mz_flag, we_flag, pa_flag;

  assign w2  = {hist_q[7:0], data_byte_i};
  assign w3  = {hist_q[15:0], data_byte_i};
  assign w4  = {hist_q, data_byte_i};
  assign sat = (pos_q == POS_MAX);
  assign skip_dec = (skip_q != 33'd0) ? skip_q - 33'd1 : skip_q;

  // Next state for one byte
  always_comb begin
    hist_d    = w3;
    pos_d     = sat ? pos_q : pos_q + POS_WIDTH'(1);
    flags_d   = flags_q;
    zip_pos_d = zip_pos_q;
    mz_pos_d  = mz_pos_q;
    phase_d   = phase_q;
    cnt_d     = cnt_q;
    clen_d    = clen_q;
    skip_d    = skip_q;
    hit_d     = hit_q;

    if (w3 == SIG_ID3 && pos_q >= POS_WIDTH'(2) && pos_q < POS_WIDTH'(id3_window_i)) begin
      flags_d[F_MP3] = 1'b1;
    end
    if (w2 == SIG_SYNC && pos_q >= POS_WIDTH'(1) && pos_q < POS_WIDTH'(sync_window_i)) begin
      flags_d[F_MP3] = 1'b1;
    end
    if (!flags_q[F_ZIP] && w4 == SIG_ZIP && pos_q >= POS_WIDTH'(3)) begin
      zip_pos_d      = sat ? POS_MAX : pos_q - POS_WIDTH'(3);
      flags_d[F_ZIP] = 1'b1;
    end
    if (!flags_q[F_MZ] && w2 == SIG_MZ && pos_q >= POS_WIDTH'(1)) begin
      mz_pos_d      = sat ? POS_MAX : pos_q - POS_WIDTH'(1);
      flags_d[F_MZ] = 1'b1;
    end
    if (pos_q == POS_WIDTH'(3)) begin
      if (w4 == MAGIC_RIFF) begin
        flags_d[F_RIFF] = 1'b1;
      end
      if (w4 == SIG_PNG) begin
        flags_d[F_PNG] = 1'b1;
      end else begin
        flags_d[F_STOP] = 1'b1;
      end
    end
    if (pos_q == POS_WIDTH'(11) && w4 == MAGIC_WAVE) begin
      flags_d[F_WAVE] = 1'b1;
    end

    // PNG chunk walk: 4 length bytes, 4 type bytes, then data plus CRC
    if (flags_q[F_PNG] && !flags_q[F_STOP] && pos_q >= POS_WIDTH'(8)) begin
      case (phase_q)
        PH_LEN: begin
          clen_d = {clen_q[23:0], data_byte_i};
          if (cnt_q == 2'd3) begin
            cnt_d   = 2'd0;
            phase_d = PH_TYPE;
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
        PH_TYPE: begin
          if (cnt_q == 2'd3) begin
            cnt_d = 2'd0;
            if (w4 == SIG_AUDT) begin
              hit_d           = {1'b1, clen_q};
              flags_d[F_STOP] = 1'b1;
            end else begin
              skip_d  = {1'b0, clen_q} + 33'd4;
              phase_d = PH_SKIP;
            end
          end else begin
            cnt_d = cnt_q + 2'd1;
          end
        end
        PH_SKIP: begin
          skip_d = skip_dec;
          if (skip_dec == 33'd0) begin
            phase_d = PH_LEN;
            clen_d  = 32'd0;
          end
        end
        default: begin
          phase_d = PH_LEN;
        end
      endcase
    end
  end

  // Result fields, taken from the state after this byte
  always_comb begin
    zip_ext = {32'd0, zip_pos_d};
    mz_ext  = {32'd0, mz_pos_d};
    mz_flag = flags_d[F_MP3] && flags_d[F_ZIP];
    we_flag = flags_d[F_RIFF] && flags_d[F_WAVE] && flags_d[F_MZ];
    pa_flag = hit_d[32];

    result_o.mp3_zip_found   = mz_flag;
    result_o.wav_exe_found   = we_flag;
    result_o.png_audio_found = pa_flag;
    result_o.any_found       = mz_flag || we_flag || pa_flag;
    result_o.audio_length    = pa_flag ? hit_d[31:0] : 32'd0;

    if (!flags_d[F_ZIP]) begin
      result_o.zip_loc = 32'd0;
    end else if (|zip_ext[POS_WIDTH+31:32]) begin
      result_o.zip_loc = 32'hFFFF_FFFF;
    end else begin
      result_o.zip_loc = zip_ext[31:0];
    end

    if (!flags_d[F_MZ]) begin
      result_o.mz_loc = 32'd0;
    end else if (|mz_ext[POS_WIDTH+31:32]) begin
      result_o.mz_loc = 32'hFFFF_FFFF;
    end else begin
      result_o.mz_loc = mz_ext[31:0];
    end
  end

  // Last byte returns the stream state to reset for the next file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hist_q    <= '0;
      pos_q     <= '0;
      flags_q   <= '0;
      zip_pos_q <= '0;
      mz_pos_q  <= '0;
      phase_q   <= PH_LEN;
      cnt_q     <= '0;
      clen_q    <= '0;
      skip_q    <= '0;
      hit_q     <= '0;
    end else if (step_i) begin
      if (last_byte_i) begin
        hist_q    <= '0;
        pos_q     <= '0;
        flags_q   <= '0;
        zip_pos_q <= '0;
        mz_pos_q  <= '0;
        phase_q   <= PH_LEN;
        cnt_q     <= '0;
        clen_q    <= '0;
        skip_q    <= '0;
        hit_q     <= '0;
      end else begin
        hist_q    <= hist_d;
        pos_q     <= pos_d;
        flags_q   <= flags_d;
        zip_pos_q <= zip_pos_d;
        mz_pos_q  <= mz_pos_d;
        phase_q   <= phase_d;
        cnt_q     <= cnt_d;
        clen_q    <= clen_d;
        skip_q    <= skip_d;
        hit_q     <= hit_d;
      end
    end
  end

endmodule

@@ hdl/polyglot_format_detector_top.sv @@
`timescale 1ns / 1ps
// A byte is registered on acceptance and scanned from that register; the result of a
// file is registered at the end of its last byte's scan cycle.
// Throughput: one byte per cycle; a last byte waits only while the previous result
// has not been taken.
// Reset (rst_ni, asynchronous, active low) clears the stream state and the valid flags
// of both channel registers and loads the window registers with 10 and 4096.
module polyglot_format_detector_top #(
  parameter int POS_WIDTH = 32
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  pfd_in_if.sink                     in_if,
  pfd_out_if.source                  out_if,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [pfd_pkg::APB_AW-1:0] paddr,
  input  logic [pfd_pkg::APB_DW-1:0] pwdata,
  output logic [pfd_pkg::APB_DW-1:0] prdata,
  output logic                       pready
);
  import pfd_pkg::*;

  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_last_q;
  logic        advance;
  logic        in_ready;
  logic        out_valid_q;
  result_t     result;
  result_t     result_q;
  logic [7:0]  id3_window;
  logic [15:0] sync_window;

  pfd_cfg u_cfg (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .id3_window_o  (id3_window),
    .sync_window_o (sync_window)
  );

  pfd_scan #(
    .POS_WIDTH (POS_WIDTH)
  ) u_scan (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (advance),
    .data_byte_i   (in_byte_q),
    .last_byte_i   (in_last_q),
    .id3_window_i  (id3_window),
    .sync_window_i (sync_window),
    .result_o      (result)
  );

  // Only a last byte needs room in the result register
  assign advance  = in_valid_q && (!in_last_q || !out_valid_q || out_if.ready);
  assign in_ready = !in_valid_q || advance;
  assign in_if.ready = in_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_if.valid && in_ready) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_ready) begin
      in_byte_q <= in_if.data_byte;
      in_last_q <= in_if.last_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_last_q) begin
      result_q <= result;
    end
  end

  assign out_if.valid           = out_valid_q;
  assign out_if.mp3_zip_found   = result_q.mp3_zip_found;
  assign out_if.zip_loc         = result_q.zip_loc;
  assign out_if.wav_exe_found   = result_q.wav_exe_found;
  assign out_if.mz_loc          = result_q.mz_loc;
  assign out_if.png_audio_found = result_q.png_audio_found;
  assign out_if.audio_length    = result_q.audio_length;
  assign out_if.any_found       = result_q.any_found;

endmodule

@@ hdl/pfd_checker.sv @@
`timescale 1ns / 1ps

module pfd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        mp3_zip_found,
  input logic        wav_exe_found,
  input logic        png_audio_found,
  input logic [31:0] audio_length,
  input logic        any_found
);

  // Input stalls only behind a last byte waiting on a full result slot
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> (any_found == (mp3_zip_found || wav_exe_found || png_audio_found)))
    else $error("any_found does not match detection flags");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !png_audio_found) |-> (audio_length == 32'd0))
    else $error("audio_length nonzero without auDT chunk");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transaction completed");

endmodule

bind polyglot_format_detector_top pfd_checker u_pfd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_ready        (in_if.ready),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .mp3_zip_found   (out_if.mp3_zip_found),
  .wav_exe_found   (out_if.wav_exe_found),
  .png_audio_found (out_if.png_audio_found),
  .audio_length    (out_if.audio_length),
  .any_found       (out_if.any_found)
);

@@ tb/sv/tb_polyglot_format_detector_top.sv @@
`timescale 1ns / 1ps

module tb_polyglot_format_detector_top;
  import pfd_pkg::*;

  localparam int STALL_LIMIT = 1000;
  localparam logic [31:0] POS_MAX = 32'hFFFFFFFF;
  localparam logic [7:0] HOT_BYTES [16] = '{
    8'h49, 8'h44, 8'h33, 8'hFF, 8'hFB, 8'h50, 8'h4B, 8'h03,
    8'h04, 8'h4D, 8'h5A, 8'h52, 8'h46, 8'h61, 8'h75, 8'h00
  };

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } file_byte_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata;
  logic [APB_DW-1:0] prdata;
  logic pready;

  pfd_in_if  byte_bus ();
  pfd_out_if find_bus ();

  polyglot_format_detector_top dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (byte_bus),
    .out_if  (find_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  file_byte_t pending_bytes[$];
  result_t    expected_findings[$];
  logic [7:0] file_buf[$];
  int         queued_bytes;
  int         mismatches;
  int         idle_odds;
  bit         hold_go;
  bit         hold_sink;
  int         src_gap;
  int         sink_gap;
  int         stall_cycles;

  // scanner copy: window registers and per-file stream state
  logic [7:0]  id3_win;
  logic [15:0] sync_win;
  logic [23:0] scan_hist;
  logic [31:0] scan_pos;
  logic [FLAG_W-1:0] scan_flags;
  logic [31:0] zip_at;
  logic [31:0] mz_at;
  phase_e      chunk_ph;
  logic [2:0]  chunk_cnt;
  logic [31:0] chunk_len;
  logic [32:0] chunk_skip;
  logic [32:0] audio_hit;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic void clear_scan();
    scan_hist  = '0;
    scan_pos   = '0;
    scan_flags = '0;
    zip_at     = '0;
    mz_at      = '0;
    chunk_ph   = PH_LEN;
    chunk_cnt  = '0;
    chunk_len  = '0;
    chunk_skip = '0;
    audio_hit  = '0;
  endfunction

  // Advances the scan by one file byte; returns 1 with the findings on the last byte.
  function automatic bit scan_byte(input logic [7:0] b, input logic last, output result_t res);
    logic [31:0] p;
    bit          sat;
    logic [15:0] w2;
    logic [23:0] w3;
    logic [31:0] w4;
    p   = scan_pos;
    sat = (p == POS_MAX);
    w2  = {scan_hist[7:0], b};
    w3  = {scan_hist[15:0], b};
    w4  = {scan_hist, b};
    res = '0;

    if (w3 == SIG_ID3 && p >= 2 && p < {24'd0, id3_win}) scan_flags[F_MP3] = 1'b1;
    if (w2 == SIG_SYNC && p >= 1 && p < {16'd0, sync_win}) scan_flags[F_MP3] = 1'b1;
    if (!scan_flags[F_ZIP] && w4 == SIG_ZIP && p >= 3) begin
      zip_at = sat ? POS_MAX : p - 3;
      scan_flags[F_ZIP] = 1'b1;
    end
    if (!scan_flags[F_MZ] && w2 == SIG_MZ && p >= 1) begin
      mz_at = sat ? POS_MAX : p - 1;
      scan_flags[F_MZ] = 1'b1;
    end
    if (p == 3) begin
      if (w4 == MAGIC_RIFF) scan_flags[F_RIFF] = 1'b1;
      if (w4 == SIG_PNG) scan_flags[F_PNG] = 1'b1;
      else scan_flags[F_STOP] = 1'b1;
    end
    if (p == 11 && w4 == MAGIC_WAVE) scan_flags[F_WAVE] = 1'b1;

    // PNG chunk walk from byte 8 on
    if (scan_flags[F_PNG] && !scan_flags[F_STOP] && p >= 8) begin
      case (chunk_ph)
        PH_LEN: begin
          chunk_len = {chunk_len[23:0], b};
          chunk_cnt++;
          if (chunk_cnt >= 4) begin
            chunk_cnt = '0;
            chunk_ph  = PH_TYPE;
          end
        end
        PH_TYPE: begin
          chunk_cnt++;
          if (chunk_cnt >= 4) begin
            chunk_cnt = '0;
            if (w4 == SIG_AUDT) begin
              audio_hit = {1'b1, chunk_len};
              scan_flags[F_STOP] = 1'b1;
            end else begin
              chunk_skip = {1'b0, chunk_len} + 33'd4;  // data plus CRC
              chunk_ph   = PH_SKIP;
            end
          end
        end
        default: begin
          if (chunk_skip != 0) chunk_skip--;
          if (chunk_skip == 0) begin
            chunk_ph  = PH_LEN;
            chunk_len = '0;
          end
        end
      endcase
    end

    scan_hist = w3;
    if (!sat) scan_pos = p + 1;
    if (!last) return 0;

    res.mp3_zip_found   = scan_flags[F_MP3] && scan_flags[F_ZIP];
    res.zip_loc         = scan_flags[F_ZIP] ? zip_at : 32'd0;
    res.wav_exe_found   = scan_flags[F_RIFF] && scan_flags[F_WAVE] && scan_flags[F_MZ];
    res.mz_loc          = scan_flags[F_MZ] ? mz_at : 32'd0;
    res.png_audio_found = audio_hit[32];
    res.audio_length    = audio_hit[32] ? audio_hit[31:0] : 32'd0;
    res.any_found       = res.mp3_zip_found | res.wav_exe_found | res.png_audio_found;
    clear_scan();
    return 1;
  endfunction

  // byte source
  always @(posedge clk_i or negedge rst_ni) begin : feed
    result_t    want;
    file_byte_t nxt;
    if (!rst_ni) begin
      byte_bus.valid     <= 1'b0;
      byte_bus.data_byte <= 8'd0;
      byte_bus.last_byte <= 1'b0;
      src_gap = 0;
      clear_scan();
    end else begin
      if (byte_bus.valid && byte_bus.ready) begin
        if (scan_byte(byte_bus.data_byte, byte_bus.last_byte, want))
          expected_findings.push_back(want);
      end
      if (!byte_bus.valid || byte_bus.ready) begin
        if (src_gap > 0) begin
          src_gap--;
          byte_bus.valid <= 1'b0;
        end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
          src_gap = $urandom_range(0, 3);
          byte_bus.valid <= 1'b0;
        end else if (pending_bytes.size() != 0) begin
          nxt = pending_bytes.pop_front();
          byte_bus.valid     <= 1'b1;
          byte_bus.data_byte <= nxt.data;
          byte_bus.last_byte <= nxt.last;
        end else begin
          byte_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted here once requested
  initial begin : long_stall
    hold_sink = 1'b0;
    wait (hold_go);
    hold_sink = 1'b1;
    repeat (150) @(posedge clk_i);
    hold_sink = 1'b0;
  end

  // findings sink and checker
  always @(posedge clk_i or negedge rst_ni) begin : watch
    result_t got;
    result_t want;
    if (!rst_ni) begin
      find_bus.ready <= 1'b0;
      sink_gap = 0;
    end else begin
      if (find_bus.valid && find_bus.ready) begin
        got.mp3_zip_found   = find_bus.mp3_zip_found;
        got.zip_loc         = find_bus.zip_loc;
        got.wav_exe_found   = find_bus.wav_exe_found;
        got.mz_loc          = find_bus.mz_loc;
        got.png_audio_found = find_bus.png_audio_found;
        got.audio_length    = find_bus.audio_length;
        got.any_found       = find_bus.any_found;
        if (expected_findings.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected findings transaction at %0t", $realtime);
        end else begin
          want = expected_findings.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("findings mismatch at %0t (mz/zip we/exe png/len any):", $realtime);
              $display("  exp %0b/%h %0b/%h %0b/%h %0b",
                       want.mp3_zip_found, want.zip_loc, want.wav_exe_found,
                       want.mz_loc, want.png_audio_found, want.audio_length,
                       want.any_found);
              $display("  got %0b/%h %0b/%h %0b/%h %0b",
                       got.mp3_zip_found, got.zip_loc, got.wav_exe_found,
                       got.mz_loc, got.png_audio_found, got.audio_length,
                       got.any_found);
            end
          end
        end
      end
      if (hold_sink) begin
        find_bus.ready <= 1'b0;
      end else if (sink_gap > 0) begin
        sink_gap--;
        find_bus.ready <= 1'b0;
      end else if (idle_odds != 0 && $urandom_range(1, idle_odds) == 1) begin
        sink_gap = $urandom_range(0, 3);
        find_bus.ready <= 1'b0;
      end else begin
        find_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((byte_bus.valid && byte_bus.ready) || (find_bus.valid && find_bus.ready) ||
          (psel && penable)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
        $display("watchdog: no transaction for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  function automatic logic [7:0] noise_byte();
    if ($urandom_range(0, 2) == 0) return HOT_BYTES[$urandom_range(0, 15)];
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic add_noise(input int n);
    for (int i = 0; i < n; i++) file_buf.push_back(noise_byte());
  endtask

  // appends the low n bytes of s, most significant first
  task automatic add_sig(input logic [31:0] s, input int n);
    for (int i = n - 1; i >= 0; i--) file_buf.push_back(s[8*i +: 8]);
  endtask

  task automatic commit_file(input bit may_cut);
    int keep;
    file_byte_t fb;
    if (may_cut && file_buf.size() > 1 && $urandom_range(0, 7) == 0) begin
      keep = $urandom_range(1, file_buf.size());
      while (file_buf.size() > keep) void'(file_buf.pop_back());
    end
    foreach (file_buf[i]) begin
      fb.data = file_buf[i];
      fb.last = (i == file_buf.size() - 1);
      pending_bytes.push_back(fb);
    end
    queued_bytes += file_buf.size();
    file_buf.delete();
  endtask

  task automatic add_file();
    int nch;
    int clen;
    case ($urandom_range(0, 9))
      0, 1: add_noise($urandom_range(1, 24));
      2, 3: begin
        add_noise(($urandom_range(0, 15) == 0) ? $urandom_range(0, 100) : $urandom_range(0, 12));
        case ($urandom_range(0, 2))
          0: add_sig(SIG_ID3, 3);
          1: add_sig(SIG_SYNC, 2);
          default: begin
            add_sig(SIG_ID3, 3);
            add_noise($urandom_range(0, 6));
            add_sig(SIG_SYNC, 2);
          end
        endcase
        add_noise($urandom_range(0, 8));
        add_sig(SIG_ZIP, ($urandom_range(0, 4) == 0) ? 3 : 4);
        add_noise($urandom_range(0, 6));
        if ($urandom_range(0, 2) == 0) add_sig(SIG_ZIP, 4);
        if ($urandom_range(0, 3) == 0) add_sig(SIG_MZ, 2);
        add_noise($urandom_range(0, 4));
      end
      4, 5: begin
        if ($urandom_range(0, 5) == 0) add_noise(4);
        else add_sig(MAGIC_RIFF, 4);
        add_noise(4);
        if ($urandom_range(0, 5) == 0) add_noise(4);
        else add_sig(MAGIC_WAVE, 4);
        add_noise($urandom_range(0, 10));
        if ($urandom_range(0, 4) != 0) add_sig(SIG_MZ, 2);
        add_noise($urandom_range(0, 6));
      end
      6, 7, 8: begin
        if ($urandom_range(0, 7) == 0) begin
          add_sig(SIG_PNG >> 8, 3);
          add_noise(1);
        end else begin
          add_sig(SIG_PNG, 4);
        end
        add_sig(32'h0D0A1A0A, 4);
        nch = $urandom_range(0, 3);
        for (int i = 0; i < nch; i++) begin
          clen = $urandom_range(0, 6);
          add_sig(clen, 4);
          add_noise(4);
          add_noise(clen + 4);
        end
        case ($urandom_range(0, 3))
          0, 1: begin
            add_sig(($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 20), 4);
            add_sig(SIG_AUDT, 4);
            add_noise($urandom_range(0, 8));
          end
          2: begin
            // declared length runs past the end of the file
            add_sig($urandom() | 32'h8000_0000, 4);
            add_noise(4);
            add_noise($urandom_range(0, 10));
          end
          default: add_noise($urandom_range(0, 3));
        endcase
      end
      default: add_noise($urandom_range(30, 80));
    endcase
    commit_file(1'b1);
  endtask

  task automatic fill_random(input int n);
    int start;
    start = queued_bytes;
    while (queued_bytes - start < n) add_file();
  endtask

  task automatic cfg_write(input logic idx, input logic [15:0] val);
    logic [31:0] junk;
    junk = $urandom();
    @(posedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= (idx == REG_ID3_WINDOW) ? {junk[31:8], val[7:0]} : {junk[31:16], val};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (idx == REG_ID3_WINDOW) id3_win = val[7:0];
    else sync_win = val;
  endtask

  // waits until every byte is taken and every finding is back
  task automatic drain();
    @(negedge clk_i);
    while (pending_bytes.size() != 0 || byte_bus.valid || expected_findings.size() != 0)
      @(negedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  initial begin
    logic [7:0]  id3_v;
    logic [15:0] sync_v;
    rst_ni         = 1'b0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    queued_bytes   = 0;
    idle_odds      = 4;
    id3_win        = ID3_WINDOW_RST;
    sync_win       = SYNC_WINDOW_RST;

    // directed files: one-byte file, MZ at offset zero, ID3 with ZIP,
    // PNG with an auDT chunk of maximum declared length
    file_buf.push_back(8'h00);
    commit_file(1'b0);
    add_sig(SIG_MZ, 2);
    commit_file(1'b0);
    add_sig(SIG_ID3, 3);
    add_sig(SIG_ZIP, 4);
    commit_file(1'b0);
    add_sig(SIG_PNG, 4);
    add_sig(32'h0D0A1A0A, 4);
    add_sig(32'hFFFFFFFF, 4);
    add_sig(SIG_AUDT, 4);
    commit_file(1'b0);
    fill_random(200);

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    drain();

    for (int ph = 0; ph < 7; ph++) begin
      case (ph)
        0: begin id3_v = 8'd3;   sync_v = 16'd2;     end
        1: begin id3_v = 8'd255; sync_v = 16'd65535; end
        2: begin id3_v = 8'd0;   sync_v = 16'd0;     end
        3: begin id3_v = 8'd1;   sync_v = 16'd1;     end
        4: begin id3_v = 8'd2;   sync_v = 16'd3;     end
        default: begin
          id3_v  = 8'($urandom_range(3, 16));
          sync_v = 16'($urandom_range(2, 24));
        end
      endcase
      cfg_write(REG_ID3_WINDOW, {8'd0, id3_v});
      cfg_write(REG_SYNC_WINDOW, sync_v);
      @(negedge clk_i);
      idle_odds = (ph == 6) ? 0 : ((ph % 2 == 0) ? 3 : 8);
      if (ph == 2) begin
        // sink holds off while many short files queue up behind it
        hold_go = 1'b1;
        for (int i = 0; i < 30; i++) begin
          add_noise($urandom_range(1, 3));
          commit_file(1'b0);
        end
      end
      fill_random(240);
      drain();
    end

    repeat (8) @(posedge clk_i);
    if (mismatches == 0 && expected_findings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
